// File: rtl/core/shtb_pkg.sv
// ----------------------------------------------------------------------------
// shtb_pkg
// Shared types and constants for the solenoid hold timer bank.
// ----------------------------------------------------------------------------
package shtb_pkg;

  localparam int unsigned NumChannels   = 40;
  localparam int unsigned CountBits     = 8;
  localparam int unsigned LockChannel   = 36;
  localparam int unsigned ChanBits      = 6;
  localparam int unsigned DurBits       = 8;
  localparam int unsigned HoldBits      = 16;
  localparam int unsigned LockBits      = 14;
  localparam int unsigned PhaseBits     = 4;
  localparam int unsigned LedBits       = 8;
  localparam int unsigned CfgIdxBits    = 2;
  localparam int unsigned CfgDataBits   = 16;

  // lock pulse train: phases up to OpenPhaseLast open, then closed up to ClosePhaseLast
  localparam logic [PhaseBits-1:0] OpenPhaseLast  = 4'd8;
  localparam logic [PhaseBits-1:0] ClosePhaseLast = 4'd10;

  localparam logic [HoldBits-1:0] PortHoldReset  = 16'd3000;
  localparam logic [LockBits-1:0] LockSolidReset = 14'd100;
  localparam logic [LockBits-1:0] LockTotalReset = 14'd16000;
  localparam logic [LedBits-1:0]  LedHalfReset   = 8'd200;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpArm   = 2'd1,
    OpLock  = 2'd2,
    OpHold  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DriveNone  = 2'd0,
    DriveOpen  = 2'd1,
    DriveClose = 2'd2
  } drive_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgPortHold  = 2'd0,
    CfgLockSolid = 2'd1,
    CfgLockTotal = 2'd2,
    CfgLedHalf   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    op_e                op;
    logic [ChanBits-1:0] channel;
    logic [DurBits-1:0]  duration;
  } in_item_t;

  typedef struct packed {
    logic [NumChannels-1:0] close_mask;
    drive_e                 lock_drive;
    logic                   port_enable;
    logic                   led_level;
  } out_item_t;

  typedef struct packed {
    logic tick;
    logic lock_start;
    logic hold_start;
  } aux_ctrl_t;

  typedef struct packed {
    logic [HoldBits-1:0] port_hold_ticks;
    logic [LockBits-1:0] lock_solid_ticks;
    logic [LockBits-1:0] lock_total_ticks;
    logic [LedBits-1:0]  led_half_period;
  } cfg_t;

endpackage

// File: rtl/core/solenoid_hold_timer_bank.sv
// ----------------------------------------------------------------------------
// solenoid_hold_timer_bank
// Tick-driven bank of one-shot channel timers with lock sequencer,
// port hold timeout and heartbeat LED.
// ----------------------------------------------------------------------------
// an accepted item waits in the input register, and its result is held in the result register
// throughput: one item per cycle unless the result side stalls, set by the input and result register pair
// the input register frees itself whenever the result register is empty or taken
// reset: asynchronous, all timers idle and counts zero, config at its defaults
module solenoid_hold_timer_bank (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  shtb_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output shtb_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [shtb_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [shtb_pkg::CfgDataBits-1:0]    cfg_wdata_i
);

  shtb_pkg::in_item_t                 in_q;
  logic                               in_valid_q, in_valid_d;
  shtb_pkg::out_item_t                out_q, out_d;
  logic                               out_valid_q, out_valid_d;
  shtb_pkg::cfg_t                     cfg_q;
  logic                               accept;
  logic                               advance;
  logic                               is_tick;
  logic                               is_arm;
  shtb_pkg::aux_ctrl_t                aux_ctrl;
  logic [shtb_pkg::NumChannels-1:0]   close_mask;
  shtb_pkg::drive_e                   aux_drive;
  logic                               port_enable;
  logic                               led_level;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_tick = advance && (in_q.op == shtb_pkg::OpTick);
  assign is_arm  = advance && (in_q.op == shtb_pkg::OpArm);

  assign aux_ctrl.tick       = is_tick;
  assign aux_ctrl.lock_start = advance && (in_q.op == shtb_pkg::OpLock);
  assign aux_ctrl.hold_start = advance && (in_q.op == shtb_pkg::OpHold);

  shtb_chan_bank u_chan_bank (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (is_tick),
    .arm_i        (is_arm),
    .arm_ch_i     (in_q.channel),
    .arm_dur_i    (in_q.duration),
    .close_mask_o (close_mask)
  );

  shtb_aux u_aux (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (aux_ctrl),
    .cfg_i         (cfg_q),
    .drive_o       (aux_drive),
    .port_enable_o (port_enable),
    .led_level_o   (led_level)
  );

  always_comb begin
    out_d.close_mask  = close_mask;
    out_d.port_enable = port_enable;
    out_d.led_level   = led_level;
    // a close of the shared channel wins over the lock sequencer
    out_d.lock_drive  = close_mask[shtb_pkg::LockChannel] ? shtb_pkg::DriveClose : aux_drive;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.port_hold_ticks  <= shtb_pkg::PortHoldReset;
      cfg_q.lock_solid_ticks <= shtb_pkg::LockSolidReset;
      cfg_q.lock_total_ticks <= shtb_pkg::LockTotalReset;
      cfg_q.led_half_period  <= shtb_pkg::LedHalfReset;
    end else if (cfg_we_i) begin
      case (shtb_pkg::cfg_idx_e'(cfg_idx_i))
        shtb_pkg::CfgPortHold: begin
          cfg_q.port_hold_ticks <= cfg_wdata_i[shtb_pkg::HoldBits-1:0];
        end
        shtb_pkg::CfgLockSolid: begin
          cfg_q.lock_solid_ticks <= cfg_wdata_i[shtb_pkg::LockBits-1:0];
        end
        shtb_pkg::CfgLockTotal: begin
          cfg_q.lock_total_ticks <= cfg_wdata_i[shtb_pkg::LockBits-1:0];
        end
        shtb_pkg::CfgLedHalf: begin
          cfg_q.led_half_period <= cfg_wdata_i[shtb_pkg::LedBits-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/core/shtb_chan_bank.sv
// ----------------------------------------------------------------------------
// shtb_chan_bank
// Row of one-shot channel counters, all advanced in parallel on a tick.
// ----------------------------------------------------------------------------
module shtb_chan_bank (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                tick_i,
  input  logic                                arm_i,
  input  logic [shtb_pkg::ChanBits-1:0]       arm_ch_i,
  input  logic [shtb_pkg::DurBits-1:0]        arm_dur_i,
  output logic [shtb_pkg::NumChannels-1:0]    close_mask_o
);

  for (genvar k = 0; k < shtb_pkg::NumChannels; k++) begin : g_chan
    logic                             active_q, active_d;
    logic [shtb_pkg::CountBits-1:0]   count_q, count_d;
    logic [shtb_pkg::CountBits-1:0]   limit_q, limit_d;
    logic [shtb_pkg::CountBits-1:0]   count_inc;
    logic                             hit;

    assign count_inc = count_q + 1'b1;
    assign hit       = tick_i && active_q && (count_inc == limit_q);

    always_comb begin
      active_d = active_q;
      count_d  = count_q;
      limit_d  = limit_q;
      if (arm_i && (arm_ch_i == shtb_pkg::ChanBits'(k))) begin
        // re-arm keeps the running count
        active_d = 1'b1;
        limit_d  = shtb_pkg::CountBits'(arm_dur_i);
      end else if (tick_i && active_q) begin
        if (hit) begin
          active_d = 1'b0;
          count_d  = '0;
        end else begin
          count_d  = count_inc;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        active_q <= 1'b0;
        count_q  <= '0;
        limit_q  <= '0;
      end else begin
        active_q <= active_d;
        count_q  <= count_d;
        limit_q  <= limit_d;
      end
    end

    assign close_mask_o[k] = hit;
  end

endmodule

// File: rtl/core/shtb_aux.sv
// ----------------------------------------------------------------------------
// shtb_aux
// Lock output sequencer, port hold timeout and heartbeat LED divider.
// ----------------------------------------------------------------------------
module shtb_aux (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  shtb_pkg::aux_ctrl_t   ctrl_i,
  input  shtb_pkg::cfg_t        cfg_i,
  output shtb_pkg::drive_e      drive_o,
  output logic                  port_enable_o,
  output logic                  led_level_o
);

  logic                              hold_active_q, hold_active_d;
  logic [shtb_pkg::HoldBits-1:0]     hold_count_q, hold_count_d;
  logic [shtb_pkg::HoldBits-1:0]     hold_inc;
  logic                              lock_active_q, lock_active_d;
  logic                              lock_restart_q, lock_restart_d;
  logic [shtb_pkg::LockBits-1:0]     lock_ticks_q, lock_ticks_d;
  logic [shtb_pkg::LockBits-1:0]     lock_base;
  logic [shtb_pkg::LockBits:0]       lock_next;
  logic [shtb_pkg::PhaseBits-1:0]    lock_phase_q, lock_phase_d;
  logic [shtb_pkg::PhaseBits-1:0]    phase_inc;
  logic [shtb_pkg::LedBits-1:0]      led_div_q, led_div_d;
  logic [shtb_pkg::LedBits-1:0]      led_inc;
  logic                              led_q, led_d;

  assign hold_inc  = hold_count_q + 1'b1;
  assign lock_base = lock_restart_q ? '0 : lock_ticks_q;
  // one bit wider so the end compare never wraps
  assign lock_next = {1'b0, lock_base} + 1'b1;
  assign phase_inc = lock_phase_q + 1'b1;
  assign led_inc   = led_div_q + 1'b1;

  always_comb begin
    hold_active_d  = hold_active_q;
    hold_count_d   = hold_count_q;
    lock_active_d  = lock_active_q;
    lock_restart_d = lock_restart_q;
    lock_ticks_d   = lock_ticks_q;
    lock_phase_d   = lock_phase_q;
    led_div_d      = led_div_q;
    led_d          = led_q;
    drive_o        = shtb_pkg::DriveNone;
    port_enable_o  = 1'b0;

    if (ctrl_i.lock_start) begin
      lock_active_d  = 1'b1;
      lock_restart_d = 1'b1;
    end

    if (ctrl_i.hold_start) begin
      hold_active_d = 1'b1;
    end

    if (ctrl_i.tick) begin
      if (hold_active_q) begin
        if (hold_inc == cfg_i.port_hold_ticks) begin
          hold_count_d  = '0;
          hold_active_d = 1'b0;
          port_enable_o = 1'b1;
        end else begin
          hold_count_d  = hold_inc;
        end
      end

      lock_ticks_d = lock_base;
      if (lock_active_q) begin
        lock_restart_d = 1'b0;
        if (lock_next < {1'b0, cfg_i.lock_solid_ticks}) begin
          drive_o = shtb_pkg::DriveOpen;
        end else if (lock_phase_q <= shtb_pkg::OpenPhaseLast) begin
          lock_phase_d = phase_inc;
          drive_o      = shtb_pkg::DriveOpen;
        end else begin
          lock_phase_d = (phase_inc > shtb_pkg::ClosePhaseLast) ? '0 : phase_inc;
          drive_o      = shtb_pkg::DriveClose;
        end
        if (lock_next > {1'b0, cfg_i.lock_total_ticks}) begin
          lock_active_d = 1'b0;
          lock_ticks_d  = '0;
          lock_phase_d  = '0;
          drive_o       = shtb_pkg::DriveClose;
        end else begin
          lock_ticks_d  = lock_next[shtb_pkg::LockBits-1:0];
        end
      end

      if (led_inc == cfg_i.led_half_period) begin
        led_div_d = '0;
        led_d     = !led_q;
      end else begin
        led_div_d = led_inc;
      end
    end
  end

  assign led_level_o = led_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_active_q  <= 1'b0;
      hold_count_q   <= '0;
      lock_active_q  <= 1'b0;
      lock_restart_q <= 1'b0;
      lock_ticks_q   <= '0;
      lock_phase_q   <= '0;
      led_div_q      <= '0;
      led_q          <= 1'b0;
    end else begin
      hold_active_q  <= hold_active_d;
      hold_count_q   <= hold_count_d;
      lock_active_q  <= lock_active_d;
      lock_restart_q <= lock_restart_d;
      lock_ticks_q   <= lock_ticks_d;
      lock_phase_q   <= lock_phase_d;
      led_div_q      <= led_div_d;
      led_q          <= led_d;
    end
  end

endmodule

// File: rtl/core/shtb_checker.sv
// ----------------------------------------------------------------------------
// shtb_checker
// Port-level checks for the solenoid hold timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module shtb_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_o,
  input  shtb_pkg::in_item_t                  in_item_i,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  shtb_pkg::out_item_t                 out_item_o
);

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  // a stalled input item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input item changed");

  // input only backs up when the result side is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room at the output");

  // a fresh result item rises only after its accepted item has passed through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result item without an accepted item");

  // shared actuator channel closing forces the lock output closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.close_mask[shtb_pkg::LockChannel]
      |-> out_item_o.lock_drive == shtb_pkg::DriveClose)
    else $error("shared channel close did not drive lock close");

endmodule

bind solenoid_hold_timer_bank shtb_checker u_shtb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// File: verif/tb_solenoid_hold_timer_bank.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_solenoid_hold_timer_bank
// Self-checking bench for the timer bank. Items go in through the
// valid/stall port with random bursts and gaps while the result side stalls
// on its own pattern. A behavioural copy of the bank predicts each item's
// close mask, lock drive, port re-enable and LED level, and results are
// checked in order. Registers are reprogrammed between phases while idle.
// ----------------------------------------------------------------------------
module tb_solenoid_hold_timer_bank;

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned HoldOffCycles = 120;

  // expected results of the bank, worked out from accepted items
  class timer_bank_board;
    bit                           chan_on [shtb_pkg::NumChannels];
    bit [shtb_pkg::CountBits-1:0] chan_count [shtb_pkg::NumChannels];
    bit [shtb_pkg::CountBits-1:0] chan_limit [shtb_pkg::NumChannels];
    bit                           hold_on;
    bit [shtb_pkg::HoldBits-1:0]  hold_count;
    bit                           lock_on;
    bit                           lock_restart;
    bit [shtb_pkg::LockBits-1:0]  lock_ticks;
    bit [shtb_pkg::PhaseBits-1:0] lock_phase;
    bit [shtb_pkg::LedBits-1:0]   led_div;
    bit                           led_on;

    bit [shtb_pkg::HoldBits-1:0]  hold_limit;
    bit [shtb_pkg::LockBits-1:0]  solid_ticks;
    bit [shtb_pkg::LockBits-1:0]  total_ticks;
    bit [shtb_pkg::LedBits-1:0]   led_half;

    shtb_pkg::out_item_t expected_results [$];
    int unsigned mismatch_count;
    int unsigned results_seen;
    int unsigned ticks, arms, lock_starts, hold_starts;
    int unsigned closes, port_pulses, lock_closes;

    function new();
      hold_limit  = shtb_pkg::PortHoldReset;
      solid_ticks = shtb_pkg::LockSolidReset;
      total_ticks = shtb_pkg::LockTotalReset;
      led_half    = shtb_pkg::LedHalfReset;
    endfunction

    function void set_reg(shtb_pkg::cfg_idx_e idx, bit [shtb_pkg::CfgDataBits-1:0] val);
      case (idx)
        shtb_pkg::CfgPortHold:  hold_limit  = val;
        shtb_pkg::CfgLockSolid: solid_ticks = val[shtb_pkg::LockBits-1:0];
        shtb_pkg::CfgLockTotal: total_ticks = val[shtb_pkg::LockBits-1:0];
        default:                led_half    = val[shtb_pkg::LedBits-1:0];
      endcase
    endfunction

    function shtb_pkg::out_item_t step_bank(shtb_pkg::in_item_t it);
      shtb_pkg::out_item_t         r;
      bit [shtb_pkg::LockBits:0]   next_ticks;
      r = '0;
      r.lock_drive = shtb_pkg::DriveNone;
      case (it.op)
        shtb_pkg::OpArm: begin
          arms++;
          if (it.channel < shtb_pkg::NumChannels) begin
            chan_on[it.channel]    = 1'b1;
            chan_limit[it.channel] = it.duration;
          end
        end
        shtb_pkg::OpLock: begin
          lock_starts++;
          lock_on      = 1'b1;
          lock_restart = 1'b1;
        end
        shtb_pkg::OpHold: begin
          hold_starts++;
          hold_on = 1'b1;
        end
        default: begin
          ticks++;
          if (hold_on) begin
            hold_count++;
            if (hold_count == hold_limit) begin
              hold_count    = '0;
              hold_on       = 1'b0;
              r.port_enable = 1'b1;
            end
          end
          if (lock_restart) lock_ticks = '0;
          if (lock_on) begin
            next_ticks   = {1'b0, lock_ticks} + 1'b1;
            lock_restart = 1'b0;
            if (next_ticks < {1'b0, solid_ticks}) begin
              r.lock_drive = shtb_pkg::DriveOpen;
            end else if (lock_phase <= shtb_pkg::OpenPhaseLast) begin
              lock_phase++;
              r.lock_drive = shtb_pkg::DriveOpen;
            end else begin
              lock_phase++;
              if (lock_phase > shtb_pkg::ClosePhaseLast) lock_phase = '0;
              r.lock_drive = shtb_pkg::DriveClose;
            end
            // compare is one bit wider so the count never wraps
            if (next_ticks > {1'b0, total_ticks}) begin
              lock_on      = 1'b0;
              lock_ticks   = '0;
              lock_phase   = '0;
              r.lock_drive = shtb_pkg::DriveClose;
            end else begin
              lock_ticks = next_ticks[shtb_pkg::LockBits-1:0];
            end
          end
          led_div++;
          if (led_div == led_half) begin
            led_div = '0;
            led_on  = !led_on;
          end
          for (int k = 0; k < shtb_pkg::NumChannels; k++) begin
            if (chan_on[k]) begin
              chan_count[k]++;
              if (chan_count[k] == chan_limit[k]) begin
                chan_on[k]       = 1'b0;
                chan_count[k]    = '0;
                r.close_mask[k]  = 1'b1;
                // shared actuator: a channel close wins over the lock
                if (k == shtb_pkg::LockChannel) r.lock_drive = shtb_pkg::DriveClose;
              end
            end
          end
          closes += $countones(r.close_mask);
          if (r.port_enable) port_pulses++;
          if (r.lock_drive == shtb_pkg::DriveClose) lock_closes++;
        end
      endcase
      r.led_level = led_on;
      return r;
    endfunction

    function void note_item(shtb_pkg::in_item_t it);
      expected_results.push_back(step_bank(it));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      mismatch_count++;
    endtask

    task check_result(shtb_pkg::out_item_t got);
      shtb_pkg::out_item_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item waiting");
        return;
      end
      want = expected_results.pop_front();
      if (got.close_mask !== want.close_mask)
        report_mismatch($sformatf("close_mask %h, want %h",
                                  got.close_mask, want.close_mask));
      if (got.lock_drive !== want.lock_drive)
        report_mismatch($sformatf("lock_drive %0d, want %0d",
                                  got.lock_drive, want.lock_drive));
      if (got.port_enable !== want.port_enable)
        report_mismatch($sformatf("port_enable %b, want %b",
                                  got.port_enable, want.port_enable));
      if (got.led_level !== want.led_level)
        report_mismatch($sformatf("led_level %b, want %b",
                                  got.led_level, want.led_level));
    endtask
  endclass

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_stall_o;
  shtb_pkg::in_item_t               in_item_i   = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  shtb_pkg::out_item_t              out_item_o;
  logic                             cfg_we_i    = 1'b0;
  logic [shtb_pkg::CfgIdxBits-1:0]  cfg_idx_i   = '0;
  logic [shtb_pkg::CfgDataBits-1:0] cfg_wdata_i = '0;

  timer_bank_board board;

  int unsigned cycle_count;
  int unsigned hold_off_req;
  int unsigned hold_off_served;
  int unsigned hold_off_left;
  int unsigned mode_left;
  int unsigned stall_mode;
  int unsigned pattern_step;
  int unsigned input_stall_cycles;

  solenoid_hold_timer_bank uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Some tests failed");
    $finish;
  end

  // result side: check what is taken, count input stalls, then choose the next stall level
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) board.check_result(out_item_o);
    if (in_valid_i && in_stall_o) input_stall_cycles++;
    if (hold_off_left == 0 && hold_off_served != hold_off_req) begin
      hold_off_served = hold_off_req;
      hold_off_left   = HoldOffCycles;
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 60);
      end
      mode_left--;
      pattern_step++;
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= (pattern_step % 3 == 0);
        default: out_stall_i <= ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  // called at a rising edge; returns at the edge that takes the item
  task automatic send_item(shtb_pkg::in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_item(it);
  endtask

  function automatic shtb_pkg::in_item_t random_item();
    shtb_pkg::in_item_t it;
    int unsigned        pick;
    int unsigned        dpick;
    pick        = $urandom_range(0, 99);
    it.channel  = shtb_pkg::ChanBits'($urandom_range(0, shtb_pkg::NumChannels - 1));
    it.duration = shtb_pkg::DurBits'($urandom_range(0, 255));
    if (pick < 55) begin
      it.op = shtb_pkg::OpTick;
    end else if (pick < 85) begin
      it.op = shtb_pkg::OpArm;
      dpick = $urandom_range(0, 9);
      if (dpick < 5) it.duration = shtb_pkg::DurBits'($urandom_range(1, 16));
      else if (dpick == 5) it.duration = 8'd0;
      else if (dpick == 6) it.duration = 8'd255;
      // channel indexes past the bank are dropped by the block
      if ($urandom_range(0, 14) == 0) begin
        it.channel = shtb_pkg::ChanBits'($urandom_range(shtb_pkg::NumChannels, 63));
      end
    end else if (pick < 92) begin
      it.op = shtb_pkg::OpLock;
    end else begin
      it.op = shtb_pkg::OpHold;
    end
    return it;
  endfunction

  task automatic run_random(int unsigned n);
    int unsigned burst;
    burst = $urandom_range(1, 24);
    for (int unsigned i = 0; i < n; i++) begin
      send_item(random_item());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(bit [15:0] hold, bit [15:0] solid, bit [15:0] total,
                              bit [15:0] led);
    shtb_pkg::cfg_idx_e order [4] = '{shtb_pkg::CfgPortHold, shtb_pkg::CfgLockSolid,
                                      shtb_pkg::CfgLockTotal, shtb_pkg::CfgLedHalf};
    bit [15:0]          vals [4];
    vals = '{hold, solid, total, led};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= order[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      board.set_reg(order[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    shtb_pkg::in_item_t directed [$];
    board = new();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // phase 1: smallest register values, directed cases first
    program_regs(16'd1, 16'd1, 16'd1, 16'd1);
    directed.push_back('{shtb_pkg::OpArm,  6'd0,  8'd1});
    directed.push_back('{shtb_pkg::OpArm,  6'd39, 8'd0});   // 256 ticks through wrap
    directed.push_back('{shtb_pkg::OpArm,  6'd38, 8'd255});
    directed.push_back('{shtb_pkg::OpArm,  6'd63, 8'd7});   // out of range, dropped
    directed.push_back('{shtb_pkg::OpArm,  6'd40, 8'd3});
    directed.push_back('{shtb_pkg::OpLock, 6'd0,  8'd0});
    directed.push_back('{shtb_pkg::OpHold, 6'd21, 8'd90});
    directed.push_back('{shtb_pkg::OpArm,  6'd36, 8'd2});   // lock channel closes on the lock
    directed.push_back('{shtb_pkg::OpTick, 6'd0,  8'd0});
    directed.push_back('{shtb_pkg::OpArm,  6'd5,  8'd3});
    directed.push_back('{shtb_pkg::OpTick, 6'd63, 8'd255});
    directed.push_back('{shtb_pkg::OpArm,  6'd5,  8'd1});   // re-arm below the count: wraps
    directed.push_back('{shtb_pkg::OpHold, 6'd0,  8'd0});
    directed.push_back('{shtb_pkg::OpTick, 6'd42, 8'd170});
    directed.push_back('{shtb_pkg::OpLock, 6'd0,  8'd0});
    directed.push_back('{shtb_pkg::OpHold, 6'd0,  8'd0});
    directed.push_back('{shtb_pkg::OpLock, 6'd0,  8'd0});   // restart while running
    for (int i = 0; i < 5; i++) directed.push_back('{shtb_pkg::OpTick, 6'd0, 8'd0});
    directed.push_back('{shtb_pkg::OpArm,  6'd1,  8'd170});
    directed.push_back('{shtb_pkg::OpArm,  6'd2,  8'd85});
    directed.push_back('{shtb_pkg::OpTick, 6'd21, 8'd85});
    foreach (directed[i]) send_item(directed[i]);
    run_random(200);
    drain();

    // phase 2: small random settings
    program_regs(16'($urandom_range(2, 30)), 16'($urandom_range(1, 15)),
                 16'($urandom_range(1, 60)), 16'($urandom_range(2, 6)));
    run_random(220);
    drain();

    // phase 3: wider settings, with a long result hold-off
    program_regs(16'($urandom_range(100, 300)), 16'($urandom_range(1, 40)),
                 16'($urandom_range(20, 300)), 16'($urandom_range(7, 50)));
    hold_off_req <= hold_off_req + 1;
    run_random(220);
    drain();

    // phase 4: largest register values, but lock solid at 16000
    program_regs(16'd65535, 16'd16000, 16'd16383, 16'd255);
    hold_off_req <= hold_off_req + 1;
    run_random(190);
    drain();

    $display("covered %0d ticks, %0d arms, %0d lock starts, %0d hold starts",
             board.ticks, board.arms, board.lock_starts, board.hold_starts);
    $display("saw %0d channel closes, %0d port re-enables, %0d lock closes",
             board.closes, board.port_pulses, board.lock_closes);
    $display("input held off for %0d cycles", input_stall_cycles);
    if (board.mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
